@@ sv/hsv2rgb_pkg.sv @@
// Shared constants and helper types for the HSV to RGB color converter.
package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W  = 15;
    localparam int UNIT_W = 16;
    localparam int PROD_W = 2 * UNIT_W;
    localparam int REM_W  = 12;
    localparam int SEC_W  = 3;

    // Number of register stages from input to output
    localparam int PIPE_DEPTH = 6;

    // Hue geometry: 60 degrees at 64 codes per degree
    localparam int DEG_PER_SECTOR = 60;
    localparam int HUE_FRAC_SCALE = 64;
    localparam int SECTOR_SPAN    = DEG_PER_SECTOR * HUE_FRAC_SCALE;
    localparam int HUE_FULL_TURN  = 6 * SECTOR_SPAN;

    localparam logic [HUE_W-1:0] HUE_TURN  = HUE_W'(HUE_FULL_TURN);
    localparam logic [HUE_W-1:0] HUE_SEC1  = HUE_W'(1 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_SEC2  = HUE_W'(2 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_SEC3  = HUE_W'(3 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_SEC4  = HUE_W'(4 * SECTOR_SPAN);
    localparam logic [HUE_W-1:0] HUE_SEC5  = HUE_W'(5 * SECTOR_SPAN);
    localparam logic [REM_W-1:0] REM_LIMIT = REM_W'(SECTOR_SPAN);

    // 65535 / 3840 reduces exactly to 4369 / 256
    localparam int FRAC_MULT_W = 13;
    localparam logic [FRAC_MULT_W-1:0] FRAC_MULT = FRAC_MULT_W'(4369);
    localparam int FRAC_SHIFT  = 8;
    localparam int FRAC_PROD_W = REM_W + FRAC_MULT_W;

    // Full-scale fraction
    localparam logic [UNIT_W-1:0] UNIT = '1;

    // Sector codes, one per 60-degree span
    localparam logic [SEC_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [SEC_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [SEC_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [SEC_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [SEC_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam logic [SEC_W-1:0] SECTOR_MAGENTA_RED   = 3'd5;

    typedef logic [UNIT_W-1:0] unorm_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [SEC_W-1:0]  sector_t;

endpackage

@@ sv/hsv2rgb_if.sv @@
// Valid/ready channel interfaces for HSV pixels in and RGB pixels out.
interface hsv2rgb_hsv_if;
    logic                              valid;
    logic                              ready;
    logic [hsv2rgb_pkg::HUE_W-1:0]     hue;
    hsv2rgb_pkg::unorm_t               saturation;
    hsv2rgb_pkg::unorm_t               brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface hsv2rgb_rgb_if;
    logic                 valid;
    logic                 ready;
    hsv2rgb_pkg::unorm_t  red;
    hsv2rgb_pkg::unorm_t  green;
    hsv2rgb_pkg::unorm_t  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ sv/hsv2rgb_unorm_div.sv @@
// Floor division of a 32-bit product by 65535, done as a fold and a small correction.
module hsv2rgb_unorm_div
(
    input  hsv2rgb_pkg::prod_t  prod,
    output hsv2rgb_pkg::unorm_t quo
);

    localparam int W = hsv2rgb_pkg::UNIT_W;

    logic [W:0]   fold;
    logic [1:0]   corr;
    logic [W:0]   quo_wide;

    // x = hi*65535 + (hi + lo), so the quotient is hi plus (hi + lo) / 65535
    always_comb
    begin
        fold = {1'b0, prod[2*W-1:W]} + {1'b0, prod[W-1:0]};
        if (fold >= {hsv2rgb_pkg::UNIT, 1'b0})
        begin
            corr = 2'd2;
        end
        else if (fold >= {1'b0, hsv2rgb_pkg::UNIT})
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
        quo_wide = {1'b0, prod[2*W-1:W]} + {{(W-1){1'b0}}, corr};
    end

    assign quo = quo_wide[W-1:0];

endmodule

@@ sv/hsv_to_rgb_converter.sv @@
// Top level of the pipelined HSV to RGB color converter.
//
// Converts one HSV pixel per clock into RGB with 16-bit fractions (65535 is 1.0)
// while the output side keeps up; hue is degrees times 64, and codes of 360
// degrees or more fold back by one turn. The pipeline has six register stages.
// The depth comes from the chain hue split, sector fraction, s*f product,
// reduction, v*(1-s*f) product, and the last reduction with the final color
// select, each step in a stage of its own with the last stage as the output
// register. A stall at the output holds each full stage with no empty stage
// between it and the output, while the stages before an empty one keep filling,
// so no pixel is lost or repeated. Zero saturation gives grey through the same
// arithmetic. No state, no memory, no clearing pass.
module hsv_to_rgb_converter
(
    input  logic                 clk,
    input  logic                 rst_n,
    hsv2rgb_hsv_if.sink          pixel_hsv,
    hsv2rgb_rgb_if.source        pixel_rgb
);

    localparam int DEPTH = hsv2rgb_pkg::PIPE_DEPTH;
    localparam int HW    = hsv2rgb_pkg::HUE_W;
    localparam int RW    = hsv2rgb_pkg::REM_W;
    localparam int FPW   = hsv2rgb_pkg::FRAC_PROD_W;
    localparam int FS    = hsv2rgb_pkg::FRAC_SHIFT;
    localparam int UW    = hsv2rgb_pkg::UNIT_W;

    // Stage control
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH-1:0] en;

    // Stage 1: folded hue split into sector and remainder
    logic [HW-1:0]          hue_fold;
    logic [HW-1:0]          hue_base;
    hsv2rgb_pkg::sector_t   sec_next;
    logic [HW-1:0]          rem_wide;
    hsv2rgb_pkg::sector_t   sec1_reg;
    logic [RW-1:0]          rem1_reg;
    hsv2rgb_pkg::unorm_t    sat1_reg;
    hsv2rgb_pkg::unorm_t    bri1_reg;

    // Stage 2: sector fraction and v*(1-s)
    logic [FPW-1:0]         frac_prod;
    hsv2rgb_pkg::unorm_t    frac2_reg;
    hsv2rgb_pkg::prod_t     prodp2_reg;
    hsv2rgb_pkg::sector_t   sec2_reg;
    hsv2rgb_pkg::unorm_t    sat2_reg;
    hsv2rgb_pkg::unorm_t    bri2_reg;

    // Stage 3: s*f and s*(1-f), reduce p
    hsv2rgb_pkg::unorm_t    p_quo;
    hsv2rgb_pkg::prod_t     prodsf3_reg;
    hsv2rgb_pkg::prod_t     prodsg3_reg;
    hsv2rgb_pkg::unorm_t    p3_reg;
    hsv2rgb_pkg::sector_t   sec3_reg;
    hsv2rgb_pkg::unorm_t    bri3_reg;

    // Stage 4: reduce s*f and s*(1-f)
    hsv2rgb_pkg::unorm_t    sf_quo;
    hsv2rgb_pkg::unorm_t    sg_quo;
    hsv2rgb_pkg::unorm_t    sf4_reg;
    hsv2rgb_pkg::unorm_t    sg4_reg;
    hsv2rgb_pkg::unorm_t    p4_reg;
    hsv2rgb_pkg::sector_t   sec4_reg;
    hsv2rgb_pkg::unorm_t    bri4_reg;

    // Stage 5: v*(1-s*f) and v*(1-s*(1-f))
    hsv2rgb_pkg::prod_t     prodq5_reg;
    hsv2rgb_pkg::prod_t     prodt5_reg;
    hsv2rgb_pkg::unorm_t    p5_reg;
    hsv2rgb_pkg::sector_t   sec5_reg;
    hsv2rgb_pkg::unorm_t    bri5_reg;

    // Stage 6: reduce q and t, select the color
    hsv2rgb_pkg::unorm_t    q_quo;
    hsv2rgb_pkg::unorm_t    t_quo;
    hsv2rgb_pkg::unorm_t    red_next;
    hsv2rgb_pkg::unorm_t    green_next;
    hsv2rgb_pkg::unorm_t    blue_next;
    hsv2rgb_pkg::unorm_t    red_reg;
    hsv2rgb_pkg::unorm_t    green_reg;
    hsv2rgb_pkg::unorm_t    blue_reg;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        en[DEPTH-1] = !vld_reg[DEPTH-1] || pixel_rgb.ready;
        for (int k = DEPTH - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    // Move valid bits along with the data
    always_comb
    begin
        vld_next[0] = en[0] ? pixel_hsv.valid : vld_reg[0];
        for (int k = 1; k < DEPTH; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Fold the hue into one turn and find its sector
    always_comb
    begin
        hue_fold = (pixel_hsv.hue >= hsv2rgb_pkg::HUE_TURN)
                 ? pixel_hsv.hue - hsv2rgb_pkg::HUE_TURN : pixel_hsv.hue;
        if (hue_fold >= hsv2rgb_pkg::HUE_SEC5)
        begin
            sec_next = hsv2rgb_pkg::SECTOR_MAGENTA_RED;
            hue_base = hsv2rgb_pkg::HUE_SEC5;
        end
        else if (hue_fold >= hsv2rgb_pkg::HUE_SEC4)
        begin
            sec_next = hsv2rgb_pkg::SECTOR_BLUE_MAGENTA;
            hue_base = hsv2rgb_pkg::HUE_SEC4;
        end
        else if (hue_fold >= hsv2rgb_pkg::HUE_SEC3)
        begin
            sec_next = hsv2rgb_pkg::SECTOR_CYAN_BLUE;
            hue_base = hsv2rgb_pkg::HUE_SEC3;
        end
        else if (hue_fold >= hsv2rgb_pkg::HUE_SEC2)
        begin
            sec_next = hsv2rgb_pkg::SECTOR_GREEN_CYAN;
            hue_base = hsv2rgb_pkg::HUE_SEC2;
        end
        else if (hue_fold >= hsv2rgb_pkg::HUE_SEC1)
        begin
            sec_next = hsv2rgb_pkg::SECTOR_YELLOW_GREEN;
            hue_base = hsv2rgb_pkg::HUE_SEC1;
        end
        else
        begin
            sec_next = hsv2rgb_pkg::SECTOR_RED_YELLOW;
            hue_base = '0;
        end
        rem_wide = hue_fold - hue_base;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec1_reg <= sec_next;
            rem1_reg <= rem_wide[RW-1:0];
            sat1_reg <= pixel_hsv.saturation;
            bri1_reg <= pixel_hsv.brightness;
        end
    end

    // Scale the remainder to a 16-bit fraction and start p
    assign frac_prod = FPW'(rem1_reg) * FPW'(hsv2rgb_pkg::FRAC_MULT);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            frac2_reg  <= frac_prod[FS+UW-1:FS];
            prodp2_reg <= hsv2rgb_pkg::PROD_W'(bri1_reg) * {{UW{1'b0}}, ~sat1_reg};
            sec2_reg   <= sec1_reg;
            sat2_reg   <= sat1_reg;
            bri2_reg   <= bri1_reg;
        end
    end

    hsv2rgb_unorm_div u_div_p
    (
        .prod (prodp2_reg),
        .quo  (p_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            prodsf3_reg <= hsv2rgb_pkg::PROD_W'(sat2_reg) * hsv2rgb_pkg::PROD_W'(frac2_reg);
            prodsg3_reg <= hsv2rgb_pkg::PROD_W'(sat2_reg) * {{UW{1'b0}}, ~frac2_reg};
            p3_reg      <= p_quo;
            sec3_reg    <= sec2_reg;
            bri3_reg    <= bri2_reg;
        end
    end

    hsv2rgb_unorm_div u_div_sf
    (
        .prod (prodsf3_reg),
        .quo  (sf_quo)
    );

    hsv2rgb_unorm_div u_div_sg
    (
        .prod (prodsg3_reg),
        .quo  (sg_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sf4_reg  <= sf_quo;
            sg4_reg  <= sg_quo;
            p4_reg   <= p3_reg;
            sec4_reg <= sec3_reg;
            bri4_reg <= bri3_reg;
        end
    end

    // Start q and t from the scaled saturation terms
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            prodq5_reg <= hsv2rgb_pkg::PROD_W'(bri4_reg) * {{UW{1'b0}}, ~sf4_reg};
            prodt5_reg <= hsv2rgb_pkg::PROD_W'(bri4_reg) * {{UW{1'b0}}, ~sg4_reg};
            p5_reg     <= p4_reg;
            sec5_reg   <= sec4_reg;
            bri5_reg   <= bri4_reg;
        end
    end

    hsv2rgb_unorm_div u_div_q
    (
        .prod (prodq5_reg),
        .quo  (q_quo)
    );

    hsv2rgb_unorm_div u_div_t
    (
        .prod (prodt5_reg),
        .quo  (t_quo)
    );

    // Pick red, green and blue by sector
    always_comb
    begin
        case (sec5_reg)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:
            begin
                red_next = bri5_reg; green_next = t_quo;    blue_next = p5_reg;
            end
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                red_next = q_quo;    green_next = bri5_reg; blue_next = p5_reg;
            end
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:
            begin
                red_next = p5_reg;   green_next = bri5_reg; blue_next = t_quo;
            end
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:
            begin
                red_next = p5_reg;   green_next = q_quo;    blue_next = bri5_reg;
            end
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                red_next = t_quo;    green_next = p5_reg;   blue_next = bri5_reg;
            end
            default:
            begin
                red_next = bri5_reg; green_next = p5_reg;   blue_next = q_quo;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // Drive the channels
    assign pixel_hsv.ready = en[0];
    assign pixel_rgb.valid = vld_reg[DEPTH-1];
    assign pixel_rgb.red   = red_reg;
    assign pixel_rgb.green = green_reg;
    assign pixel_rgb.blue  = blue_reg;

    // An empty output stage lets the whole pipe advance
    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[DEPTH-1] |-> pixel_hsv.ready)
        else $error("input stalled while output stage is empty");

    // A held stage keeps its valid bit
    a_held_stage_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !en[2]) |=> vld_reg[2])
        else $error("stalled stage dropped its item");

    // Sector and remainder stay in range
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (sec1_reg <= hsv2rgb_pkg::SECTOR_MAGENTA_RED
                        && rem1_reg < hsv2rgb_pkg::REM_LIMIT))
        else $error("hue split out of range");

    // An accepted item is in the first stage next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_hsv.valid && pixel_hsv.ready) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

endmodule

@@ verif/hsv_to_rgb_converter_checker.sv @@
// Checker for the HSV to RGB converter: predicts each RGB item and compares it on arrival.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_checker
(
    input  logic     clk,
    input  logic     rst_n,
    hsv2rgb_hsv_if   pixel_hsv,
    hsv2rgb_rgb_if   pixel_rgb,
    output int       mismatches,
    output int       backlog
);

    typedef struct packed {
        hsv2rgb_pkg::unorm_t red;
        hsv2rgb_pkg::unorm_t green;
        hsv2rgb_pkg::unorm_t blue;
    } rgb_pixel_t;

    localparam longint unsigned FULL_SCALE = 64'(hsv2rgb_pkg::UNIT);
    localparam longint unsigned SPAN       = 64'(hsv2rgb_pkg::SECTOR_SPAN);
    localparam longint unsigned TURN       = 64'(hsv2rgb_pkg::HUE_FULL_TURN);

    rgb_pixel_t expected_rgb[$];
    int         fail_total = 0;
    int         queued     = 0;

    assign mismatches = fail_total;
    assign backlog    = queued;

    // Multiply two fractions and renormalize, flooring the quotient
    function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b);
        return (a * b) / FULL_SCALE;
    endfunction

    // Compute the RGB color for one HSV pixel
    function automatic rgb_pixel_t convert_hsv_pixel(
        logic [hsv2rgb_pkg::HUE_W-1:0] hue_code,
        hsv2rgb_pkg::unorm_t sat, hsv2rgb_pkg::unorm_t val);
        longint unsigned      h;
        longint unsigned      s;
        longint unsigned      v;
        longint unsigned      frac;
        longint unsigned      p;
        longint unsigned      q;
        longint unsigned      t;
        hsv2rgb_pkg::unorm_t  pu;
        hsv2rgb_pkg::unorm_t  qu;
        hsv2rgb_pkg::unorm_t  tu;
        hsv2rgb_pkg::unorm_t  vu;
        hsv2rgb_pkg::sector_t sec;
        rgb_pixel_t           px;
        h = 64'(hue_code);
        s = 64'(sat);
        v = 64'(val);
        // Fold codes of a full turn or more back into range
        if (h >= TURN)
            h = h - TURN;
        // Grey when there is no saturation
        if (s == 0)
        begin
            px.red   = val;
            px.green = val;
            px.blue  = val;
            return px;
        end
        sec  = hsv2rgb_pkg::sector_t'(h / SPAN);
        frac = ((h % SPAN) * FULL_SCALE) / SPAN;
        p = mul_frac(v, FULL_SCALE - s);
        q = mul_frac(v, FULL_SCALE - mul_frac(s, frac));
        t = mul_frac(v, FULL_SCALE - mul_frac(s, FULL_SCALE - frac));
        pu = hsv2rgb_pkg::unorm_t'(p);
        qu = hsv2rgb_pkg::unorm_t'(q);
        tu = hsv2rgb_pkg::unorm_t'(t);
        vu = hsv2rgb_pkg::unorm_t'(v);
        case (sec)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:   px = {vu, tu, pu};
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN: px = {qu, vu, pu};
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:   px = {pu, vu, tu};
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:    px = {pu, qu, vu};
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: px = {tu, pu, vu};
            default:                          px = {vu, pu, qu};
        endcase
        return px;
    endfunction

    task automatic compare_component(string name, hsv2rgb_pkg::unorm_t want,
                                     hsv2rgb_pkg::unorm_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    // Retire arriving items first, then queue the prediction for a newly taken one
    always @(posedge clk)
    begin
        rgb_pixel_t oldest;
        if (rst_n)
        begin
            if (pixel_rgb.valid && pixel_rgb.ready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    $error("rgb item with no pending expectation: %0d %0d %0d",
                           pixel_rgb.red, pixel_rgb.green, pixel_rgb.blue);
                    fail_total++;
                end
                else
                begin
                    oldest = expected_rgb.pop_front();
                    compare_component("red",   oldest.red,   pixel_rgb.red);
                    compare_component("green", oldest.green, pixel_rgb.green);
                    compare_component("blue",  oldest.blue,  pixel_rgb.blue);
                end
            end
            if (pixel_hsv.valid && pixel_hsv.ready)
                expected_rgb.push_back(convert_hsv_pixel(pixel_hsv.hue,
                                                         pixel_hsv.saturation,
                                                         pixel_hsv.brightness));
            queued = expected_rgb.size();
        end
    end

endmodule

@@ verif/hsv_to_rgb_converter_tb.sv @@
// Testbench top for the HSV to RGB converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;

    localparam int ITEMS_PER_PHASE = 284;
    localparam int DRAIN_CYCLES    = 4 * hsv2rgb_pkg::PIPE_DEPTH;
    localparam int HW              = hsv2rgb_pkg::HUE_W;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   backlog;
    int   tx_idle_pct;
    int   rx_idle_pct;

    hsv2rgb_hsv_if pixel_hsv();
    hsv2rgb_rgb_if pixel_rgb();

    hsv_to_rgb_converter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_hsv (pixel_hsv),
        .pixel_rgb (pixel_rgb)
    );

    hsv_to_rgb_converter_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_hsv  (pixel_hsv),
        .pixel_rgb  (pixel_rgb),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Known values on every input from time zero
    initial
    begin
        rst_n                = 1'b0;
        tx_idle_pct          = 0;
        rx_idle_pct          = 0;
        pixel_hsv.valid      = 1'b0;
        pixel_hsv.hue        = '0;
        pixel_hsv.saturation = '0;
        pixel_hsv.brightness = '0;
        pixel_rgb.ready      = 1'b0;
    end

    // Stall the output side at random
    always @(negedge clk)
    begin
        pixel_rgb.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one item, idling first at random, and hold it until taken
    task automatic send_pixel(logic [HW-1:0] h, hsv2rgb_pkg::unorm_t s,
                              hsv2rgb_pkg::unorm_t v);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pixel_hsv.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_hsv.valid      <= 1'b1;
        pixel_hsv.hue        <= h;
        pixel_hsv.saturation <= s;
        pixel_hsv.brightness <= v;
        @(posedge clk);
        while (!pixel_hsv.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted item has come back
    task automatic wait_for_drain();
        @(negedge clk);
        pixel_hsv.valid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
    endtask

    function automatic hsv2rgb_pkg::unorm_t pick_fraction();
        int kind;
        kind = $urandom_range(9);
        if (kind == 0)
            return '0;
        if (kind == 1)
            return hsv2rgb_pkg::UNIT;
        return hsv2rgb_pkg::unorm_t'($urandom());
    endfunction

    // Mostly in-range hues, with sector edges and wrapped codes mixed in
    function automatic logic [HW-1:0] pick_hue();
        int kind;
        int edge_hue;
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            edge_hue = $urandom_range(6) * hsv2rgb_pkg::SECTOR_SPAN + $urandom_range(2) - 1;
            if (edge_hue < 0)
                edge_hue = 0;
            return HW'(edge_hue);
        end
        if (kind <= 2)
            return HW'($urandom_range(32767, hsv2rgb_pkg::HUE_FULL_TURN));
        return HW'($urandom_range(hsv2rgb_pkg::HUE_FULL_TURN - 1));
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: sector edges, extremes, grey, black, wrapped hues
        send_pixel(15'd0,                 16'd65535, 16'd65535);
        send_pixel(15'd3839,              16'd65535, 16'd65535);
        send_pixel(hsv2rgb_pkg::HUE_SEC1, 16'd65535, 16'd65535);
        send_pixel(15'd7679,              16'd40000, 16'd50000);
        send_pixel(hsv2rgb_pkg::HUE_SEC2, 16'd65535, 16'd65535);
        send_pixel(hsv2rgb_pkg::HUE_SEC3, 16'd30000, 16'd60000);
        send_pixel(hsv2rgb_pkg::HUE_SEC4, 16'd65535, 16'd65535);
        send_pixel(hsv2rgb_pkg::HUE_SEC5, 16'd65535, 16'd65535);
        send_pixel(15'd23039,             16'd65535, 16'd65535);
        send_pixel(hsv2rgb_pkg::HUE_TURN, 16'd65535, 16'd65535);
        send_pixel(15'd32767,             16'd12345, 16'd65535);
        send_pixel(15'd32767,             16'd65535, 16'd65535);
        send_pixel(15'd26000,             16'd32768, 16'd32768);
        send_pixel(15'd1920,              16'd0,     16'd40000);
        send_pixel(15'd30000,             16'd0,     16'd0);
        send_pixel(15'd0,                 16'd0,     16'd65535);
        send_pixel(15'd5000,              16'd65535, 16'd0);
        send_pixel(15'd0,                 16'd1,     16'd65535);
        send_pixel(15'd12000,             16'd65534, 16'd1);
        send_pixel(15'd16000,             16'd1,     16'd1);
        send_pixel(15'd21111,             16'd43690, 16'd21845);
        wait_for_drain();

        // Random: three phases with different idle rates, each with a hold-off midway
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 15; rx_idle_pct = 85; end
                1:       begin tx_idle_pct = 85; rx_idle_pct = 15; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    wait_for_drain();
                send_pixel(pick_hue(), pick_fraction(), pick_fraction());
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("hsv_to_rgb_converter: match");
        else
            $display("hsv_to_rgb_converter: mismatch");
        $finish;
    end

    // Give up on a hung handshake
    initial
    begin
        #2000000;
        $display("hsv_to_rgb_converter: mismatch");
        $finish;
    end

endmodule
